/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, off while reset is held
`define CST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check, sampled also during reset
`define CST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cst_pkg.sv */
// shared types and constants of the client slot table
package cst_pkg;

  localparam int DEF_SLOTS = 16;
  localparam int KEY_W     = 32;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int OCC_W     = 5;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/core/cst_ram.sv */
// generic single write port ram with registered read
module cst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/cst_datapath.sv */
// slot storage, scan pipeline, occupancy tracking and result register
module cst_datapath #(
  parameter int SLOTS = cst_pkg::DEF_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cst_pkg::ctl_cmd_t         cmd,
  output cst_pkg::dp_sts_t          sts,
  input  logic [1:0]                in_op,
  input  logic [cst_pkg::KEY_W-1:0] in_key,
  input  logic                      in_auth_in,
  input  logic [cst_pkg::TIME_W-1:0] in_time_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_ok,
  output logic [cst_pkg::SLOT_W-1:0] out_slot,
  output logic                      out_auth_out,
  output logic [cst_pkg::TIME_W-1:0] out_time_out,
  output logic [cst_pkg::OCC_W-1:0] out_occupied
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = cst_pkg::TIME_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // captured operation
  logic [1:0]                 op_r;
  logic [cst_pkg::KEY_W-1:0]  key_r;
  logic                       auth_r;
  logic [cst_pkg::TIME_W-1:0] time_r;

  // read issue and compare stages
  logic [IW-1:0] rd_idx_r;
  logic          rd_live_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;

  // slots holding a nonzero key, and their count
  logic [SLOTS-1:0] occ_r, occ_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // result of the current operation
  logic                       res_ok_r;
  logic [IW-1:0]              res_slot_r;
  logic                       res_auth_r;
  logic [cst_pkg::TIME_W-1:0] res_time_r;

  logic                       out_valid_r;
  logic                       out_ok_r;
  logic [cst_pkg::SLOT_W-1:0] out_slot_r;
  logic                       out_auth_r;
  logic [cst_pkg::TIME_W-1:0] out_time_r;
  logic [cst_pkg::OCC_W-1:0]  out_occ_r;

  logic [cst_pkg::KEY_W-1:0] key_rd;
  logic [PW-1:0]             pay_rd;

  logic eval, slot_used, key_match, is_last;
  logic op_app, op_del, op_find, op_other;
  logic app_hit, find_hit, del_hit;

  cst_ram #(.WIDTH(cst_pkg::KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (app_hit),
    .waddr (cmp_idx_r),
    .wdata (key_r),
    .raddr (rd_idx_r),
    .rdata (key_rd)
  );

  cst_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (app_hit),
    .waddr (cmp_idx_r),
    .wdata ({auth_r, time_r}),
    .raddr (rd_idx_r),
    .rdata (pay_rd)
  );

  always_comb begin
    op_app    = (op_r == cst_pkg::OP_APPEND);
    op_del    = (op_r == cst_pkg::OP_DELETE);
    op_find   = (op_r == cst_pkg::OP_FIND);
    op_other  = !(op_app || op_del || op_find);
    eval      = cmd.scan && cmp_vld_r;
    slot_used = occ_r[cmp_idx_r];
    key_match = slot_used && (key_rd == key_r);
    is_last   = (cmp_idx_r == LAST_IDX);
    app_hit   = eval && op_app && !slot_used;
    find_hit  = eval && op_find && (key_r != '0) && key_match;
    del_hit   = eval && op_del && key_match;
    sts.done  = op_other || (eval && (app_hit || find_hit || is_last));
    sts.out_free = !(out_valid_r && out_stall);
  end

  // occupancy: a zero key written by append leaves the slot free
  always_comb begin
    occ_nxt = occ_r;
    cnt_nxt = cnt_r;
    if (app_hit && (key_r != '0)) begin
      occ_nxt[cmp_idx_r] = 1'b1;
      cnt_nxt            = cnt_r + CW'(1);
    end else if (del_hit) begin
      occ_nxt[cmp_idx_r] = 1'b0;
      cnt_nxt            = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      cnt_r     <= '0;
      rd_live_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.start) begin
        rd_live_r <= 1'b1;
        cmp_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= rd_live_r;
        if (rd_idx_r == LAST_IDX) begin
          rd_live_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r       <= in_op;
      key_r      <= in_key;
      auth_r     <= in_auth_in;
      time_r     <= in_time_in;
      rd_idx_r   <= '0;
      res_ok_r   <= (in_op == cst_pkg::OP_DELETE);
      res_slot_r <= '0;
      res_auth_r <= 1'b0;
      res_time_r <= '0;
    end else begin
      if (cmd.scan && rd_live_r) begin
        cmp_idx_r <= rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_r <= rd_idx_r + IW'(1);
        end
      end
      if (app_hit) begin
        res_ok_r   <= 1'b1;
        res_slot_r <= cmp_idx_r;
      end else if (find_hit) begin
        res_ok_r   <= 1'b1;
        res_slot_r <= cmp_idx_r;
        res_auth_r <= pay_rd[PW-1];
        res_time_r <= pay_rd[cst_pkg::TIME_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok_r   <= res_ok_r;
      out_slot_r <= cst_pkg::SLOT_W'(res_slot_r);
      out_auth_r <= res_auth_r;
      out_time_r <= res_time_r;
      out_occ_r  <= cst_pkg::OCC_W'(cnt_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_slot     = out_slot_r;
  assign out_auth_out = out_auth_r;
  assign out_time_out = out_time_r;
  assign out_occupied = out_occ_r;

endmodule

/* rtl/core/cst_ctrl.sv */
// sequencer: accept, scan the slots, hand the result to the output register
module cst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cst_pkg::dp_sts_t  sts,
  output cst_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.start    = 1'b0;
    cmd.scan     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

/* rtl/core/client_slot_table_core.sv */
// top level of the client slot table
// usage:
//   input channel in_valid/in_stall carries one command beat: op (append,
//   delete, find), key, auth flag and connect time. a beat is taken when
//   in_valid is high and in_stall low.
//   result channel out_valid/out_stall returns exactly one beat per command:
//   ok, slot, stored auth flag and time of a find hit, and the number of
//   occupied slots after the command.
//   the slots are walked one per cycle through the key ram's registered read
//   port, so a find or append stops early at its first hit while a delete
//   always walks the whole table. an unused op code ends the command without
//   walking the table.
//   throughput is one command per scan; a new command is accepted as soon as
//   the previous result sits in the output register, even while stalled.
//   a stalled result holds in the output register; the next result waits in
//   the sequencer until that beat is taken.
//   reset (rst_n low, synchronous) marks every slot free at once through a
//   per-slot occupancy flag, so no clearing pass is needed; auth and time of
//   a slot are only ever read after an append has written them.
module client_slot_table_core #(
  parameter int SLOTS = cst_pkg::DEF_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [cst_pkg::KEY_W-1:0]   in_key,
  input  logic                        in_auth_in,
  input  logic [cst_pkg::TIME_W-1:0]  in_time_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [cst_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_auth_out,
  output logic [cst_pkg::TIME_W-1:0]  out_time_out,
  output logic [cst_pkg::OCC_W-1:0]   out_occupied
);

  cst_pkg::ctl_cmd_t cmd;
  cst_pkg::dp_sts_t  sts;

  // sequencer: idle -> scan -> hand-off
  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot rams, occupancy flags, compare stage and output register
  cst_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_op),
    .in_key       (in_key),
    .in_auth_in   (in_auth_in),
    .in_time_in   (in_time_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_slot     (out_slot),
    .out_auth_out (out_auth_out),
    .out_time_out (out_time_out),
    .out_occupied (out_occupied)
  );

endmodule

/* rtl/core/cst_checker.sv */
// port-level checks of the client slot table, bound to the top level
`include "assert_macros.svh"

module cst_checker #(
  parameter int SLOTS = cst_pkg::DEF_SLOTS
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_ok,
  input logic [cst_pkg::SLOT_W-1:0]  out_slot,
  input logic                        out_auth_out,
  input logic [cst_pkg::TIME_W-1:0]  out_time_out,
  input logic [cst_pkg::OCC_W-1:0]   out_occupied
);

  localparam logic [cst_pkg::OCC_W-1:0] MAX_OCC = cst_pkg::OCC_W'(SLOTS);
  localparam bit OCC_FITS = (SLOTS < (1 << cst_pkg::OCC_W));

  // a result beat holds while stalled
  `CST_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")

  // one command at a time: an accepted beat blocks the next cycle
  `CST_ASSERT(a_one_cmd, clk, rst_n, in_valid && !in_stall |=> in_stall, "second command taken during a scan")

  // a failed command reports no slot and no stored data
  `CST_ASSERT(a_miss_clean, clk, rst_n, out_valid && !out_ok |-> out_slot == '0 && !out_auth_out && out_time_out == '0, "miss result carries data")

  // occupancy never exceeds the table size
  `CST_ASSERT(a_occ_range, clk, rst_n, out_valid |-> !OCC_FITS || out_occupied <= MAX_OCC, "occupied count above table size")

  // nothing leaves the block right out of reset
  `CST_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid && !in_stall, "outputs active after reset")

endmodule

bind client_slot_table_core cst_checker #(.SLOTS(SLOTS)) u_cst_checker (.*);

/* test/client_slot_table_core_tb.sv */
// self-checking testbench of the client slot table core
module client_slot_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = cst_pkg::DEF_SLOTS;
  localparam int KEY_W = cst_pkg::KEY_W;
  localparam int TIME_W = cst_pkg::TIME_W;
  localparam int SLOT_W = cst_pkg::SLOT_W;
  localparam int OCC_W = cst_pkg::OCC_W;
  // op code 3 is not assigned, the block must leave the table alone
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles without any accepted beat before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // settle time after the last result, scaled with the number of slots
  localparam int TAIL_CYCLES = 2 * SLOTS + 8;
  localparam int POOL_SIZE = 8;
  localparam int SEGMENTS = 5;
  localparam int SEGMENT_ITEMS = 265;

  // one expected result beat
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              auth;
    logic [TIME_W-1:0] stamp;
    logic [OCC_W-1:0]  occupied;
  } table_result_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // shadow copy of the slot table plus the queue of results still owed
  class slot_table_scoreboard;
    logic [KEY_W-1:0]  key_mem[SLOTS];
    logic              auth_mem[SLOTS];
    logic [TIME_W-1:0] time_mem[SLOTS];
    table_result_t     owed_q[$];
    int                errors;
    int                op_count[4];
    int                append_full;
    int                find_hits;
    int                peak_occupied;
    int                results_seen;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        key_mem[i] = '0;
        auth_mem[i] = 1'b0;
        time_mem[i] = '0;
      end
      errors = 0;
      append_full = 0;
      find_hits = 0;
      peak_occupied = 0;
      results_seen = 0;
      for (int i = 0; i < 4; i++) op_count[i] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // apply one accepted command to the shadow table and queue its result
    function void note_command(logic [1:0] op, logic [KEY_W-1:0] key, logic auth,
                               logic [TIME_W-1:0] stamp);
      table_result_t res;
      bit            hit;
      int            occ;
      res = '0;
      hit = 1'b0;
      occ = 0;
      op_count[op]++;
      case (op)
        cst_pkg::OP_APPEND: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && key_mem[i] == '0) begin
              hit = 1'b1;
              key_mem[i] = key;
              auth_mem[i] = auth;
              time_mem[i] = stamp;
              res.ok = 1'b1;
              res.slot = SLOT_W'(i);
            end
          end
          if (!hit) append_full++;
        end
        cst_pkg::OP_DELETE: begin
          // a zero key would match free slots, which are already free
          if (key != '0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (key_mem[i] == key) key_mem[i] = '0;
            end
          end
          res.ok = 1'b1;
        end
        cst_pkg::OP_FIND: begin
          if (key != '0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!hit && key_mem[i] == key) begin
                hit = 1'b1;
                res.ok = 1'b1;
                res.slot = SLOT_W'(i);
                res.auth = auth_mem[i];
                res.stamp = time_mem[i];
              end
            end
          end
          if (hit) find_hits++;
        end
        default: begin
        end
      endcase
      for (int i = 0; i < SLOTS; i++) begin
        if (key_mem[i] != '0) occ++;
      end
      if (occ > peak_occupied) peak_occupied = occ;
      res.occupied = OCC_W'(occ);
      owed_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    // compare one accepted result beat with the oldest owed result
    function void check_result(table_result_t act);
      table_result_t exp_res;
      results_seen++;
      if (owed_q.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none actual %h", $time, act);
        errors++;
        return;
      end
      exp_res = owed_q.pop_front();
      compare_field("ok", exp_res.ok, act.ok);
      compare_field("slot", exp_res.slot, act.slot);
      compare_field("auth_out", exp_res.auth, act.auth);
      compare_field("time_out", exp_res.stamp, act.stamp);
      compare_field("occupied", exp_res.occupied, act.occupied);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_op = cst_pkg::OP_APPEND;
  logic [KEY_W-1:0]  in_key = '0;
  logic              in_auth_in = 1'b0;
  logic [TIME_W-1:0] in_time_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_ok;
  logic [SLOT_W-1:0] out_slot;
  logic              out_auth_out;
  logic [TIME_W-1:0] out_time_out;
  logic [OCC_W-1:0]  out_occupied;

  slot_table_scoreboard sb;
  logic [KEY_W-1:0]     key_pool[POOL_SIZE];
  stall_mode_t          stall_mode = STALL_NONE;
  int                   stall_left = 0;
  int                   cycle_cnt = 0;
  int                   idle_cnt = 0;

  client_slot_table_core #(
    .SLOTS(SLOTS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_key      (in_key),
    .in_auth_in  (in_auth_in),
    .in_time_in  (in_time_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_ok      (out_ok),
    .out_slot    (out_slot),
    .out_auth_out(out_auth_out),
    .out_time_out(out_time_out),
    .out_occupied(out_occupied)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitors: sample at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_command(in_op, in_key, in_auth_in, in_time_in);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_ok, out_slot, out_auth_out, out_time_out, out_occupied});
    end
  end

  // receiver back-pressure: switch style at random intervals
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= ((cycle_cnt % 7) < 3);
      default:        out_stall <= 1'b0;
    endcase
  end

  // watchdog: any beat on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d results owed", $time, idle_cnt,
                 sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // present one command beat and hold it until the block takes it
  task automatic send_cmd(input logic [1:0] op, input logic [KEY_W-1:0] key,
                          input logic auth, input logic [TIME_W-1:0] stamp);
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_auth_in <= auth;
    in_time_in <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender off until every owed result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // one random command: mostly pool keys so that finds hit and deletes free slots
  task automatic send_random_cmd(input int append_pct);
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      op = OP_UNUSED;
    end else if (pick < 5 + append_pct) begin
      op = cst_pkg::OP_APPEND;
    end else if (pick < 5 + append_pct + (95 - append_pct) / 3) begin
      op = cst_pkg::OP_DELETE;
    end else begin
      op = cst_pkg::OP_FIND;
    end
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick < 83) begin
      key = '0;
    end else begin
      key = $urandom;
    end
    send_cmd(op, key, 1'($urandom_range(0, 1)), $urandom);
  endtask

  initial begin
    int burst;
    int sent;
    int append_pct[SEGMENTS];
    append_pct = '{60, 40, 25, 50, 70};
    sb = new();
    for (int k = 0; k < POOL_SIZE; k++) begin
      do key_pool[k] = $urandom; while (key_pool[k] == '0);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: misses and zero keys on an empty table
    send_cmd(cst_pkg::OP_FIND, key_pool[0], 1'b0, '0);
    send_cmd(cst_pkg::OP_DELETE, '0, 1'b1, '1);
    // zero-key append reports slot 0 but leaves it free
    send_cmd(cst_pkg::OP_APPEND, '0, 1'b1, '1);
    idle_cycles(2);
    send_cmd(cst_pkg::OP_FIND, '0, 1'b0, '0);
    // all-ones key, stored twice since duplicates are not checked
    send_cmd(cst_pkg::OP_APPEND, '1, 1'b1, '1);
    send_cmd(cst_pkg::OP_APPEND, '1, 1'b0, '0);
    send_cmd(cst_pkg::OP_FIND, '1, 1'b0, '0);
    idle_cycles(1);
    send_cmd(OP_UNUSED, '1, 1'b1, '1);
    // delete clears both copies
    send_cmd(cst_pkg::OP_DELETE, '1, 1'b0, '0);
    // fill every slot from the pool, each key twice
    for (int i = 0; i < SLOTS; i++) begin
      send_cmd(cst_pkg::OP_APPEND, key_pool[i % POOL_SIZE], i[0], $urandom);
      if ((i % 5) == 4) idle_cycles($urandom_range(1, 3));
    end
    // append into a full table fails and changes nothing
    send_cmd(cst_pkg::OP_APPEND, key_pool[1], 1'b1, '1);
    send_cmd(cst_pkg::OP_FIND, key_pool[3], 1'b0, '0);
    wait_results_drained();

    // random segments with different append bias, drained between them
    for (int s = 0; s < SEGMENTS; s++) begin
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && sent < SEGMENT_ITEMS; b++) begin
          send_random_cmd(append_pct[s]);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 15));
      end
      wait_results_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("commands: %0d append (%0d full), %0d delete, %0d find (%0d hits), %0d unused",
             sb.op_count[cst_pkg::OP_APPEND], sb.append_full,
             sb.op_count[cst_pkg::OP_DELETE], sb.op_count[cst_pkg::OP_FIND],
             sb.find_hits, sb.op_count[OP_UNUSED]);
    $display("results checked: %0d, peak occupancy %0d of %0d slots, %0d errors",
             sb.results_seen, sb.peak_occupied, SLOTS, sb.errors + sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
